FILE: hw/rtl/per_flow_token_bucket_limiter_assert.svh
// ----------------------------------------------------------------------------
// Per-flow token bucket limiter assertion macros
// Shared concurrent assertion forms used by the limiter RTL.
// ----------------------------------------------------------------------------
`ifndef PER_FLOW_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define PER_FLOW_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// Condition must never hold outside reset.
`define PFTBL_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PFTBL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PFTBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pftbl_pkg.sv
// ----------------------------------------------------------------------------
// Per-flow token bucket limiter package
// Types, constants and register codes shared by the limiter modules.
// ----------------------------------------------------------------------------
package pftbl_pkg;

   localparam int FLOW_ENTRIES = 64;
   localparam int KEY_W        = 104;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [31:0] SRC_IP_MASK    = 32'hFFFF_FFF0;

   localparam logic [1:0] VERDICT_PASS      = 2'd0;
   localparam logic [1:0] VERDICT_DROP_RATE = 2'd1;
   localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

   localparam logic [1:0] REG_RATE_SHIFT = 2'd0;
   localparam logic [1:0] REG_MAX_TOKENS = 2'd1;
   localparam logic [1:0] REG_COST       = 2'd2;

   localparam logic [5:0]  RATE_SHIFT_RESET = 6'd10;
   localparam logic [15:0] MAX_TOKENS_RESET = 16'd16;
   localparam logic [15:0] COST_RESET       = 16'd1;

   typedef struct packed {
      logic [15:0] ether_type;
      logic        headers_complete;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        tcp_fin;
      logic [63:0] now_ns;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic        flow_hit;
      logic        flow_inserted;
      logic        flow_removed;
      logic        table_full;
      logic [15:0] tokens_left;
   } rsp_type;

   typedef struct packed {
      logic             do_match;
      logic             do_select;
      logic             do_write_hit;
      logic             do_write_ins;
      logic             wr_valid;
      logic [KEY_W-1:0] key;
      logic [15:0]      tokens;
      logic [63:0]      stamp;
   } cmd_type;

   typedef struct packed {
      logic        hit_seen;
      logic        free_seen;
      logic [15:0] tokens;
      logic [63:0] stamp;
   } chain_type;

endpackage

FILE: hw/rtl/pftbl_cell.sv
// ----------------------------------------------------------------------------
// Flow table cell
// Holds one flow entry, matches the broadcast key and passes the hit and
// free search along the chain to its neighbor.
// ----------------------------------------------------------------------------
module pftbl_cell (
   input  logic                clock,
   input  logic                reset,
   input  pftbl_pkg::cmd_type   cmd,
   input  pftbl_pkg::chain_type chain_in,
   output pftbl_pkg::chain_type chain_out
);

   logic                         valid_ff;
   logic [pftbl_pkg::KEY_W-1:0]  key_ff;
   logic [15:0]                  tokens_ff;
   logic [63:0]                  stamp_ff;
   logic                         match_ff;
   logic                         sel_hit_ff;
   logic                         sel_free_ff;
   logic                         hit_now;
   logic                         free_now;
   logic                         wr_hit;
   logic                         wr_ins;

   assign hit_now  = match_ff && !chain_in.hit_seen;
   assign free_now = !valid_ff && !chain_in.free_seen;
   assign wr_hit   = cmd.do_write_hit && sel_hit_ff;
   assign wr_ins   = cmd.do_write_ins && sel_free_ff;

   always_comb begin
      chain_out.hit_seen  = chain_in.hit_seen || match_ff;
      chain_out.free_seen = chain_in.free_seen || !valid_ff;
      chain_out.tokens    = chain_in.tokens | (hit_now ? tokens_ff : 16'd0);
      chain_out.stamp     = chain_in.stamp | (hit_now ? stamp_ff : 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         match_ff    <= 1'b0;
         sel_hit_ff  <= 1'b0;
         sel_free_ff <= 1'b0;
      end else begin
         if (wr_hit) begin
            valid_ff <= cmd.wr_valid;
         end else if (wr_ins) begin
            valid_ff <= 1'b1;
         end
         if (cmd.do_match) begin
            match_ff <= valid_ff && (key_ff == cmd.key);
         end
         if (cmd.do_select) begin
            sel_hit_ff  <= hit_now;
            sel_free_ff <= free_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit || wr_ins) begin
         key_ff    <= cmd.key;
         tokens_ff <= cmd.tokens;
         stamp_ff  <= cmd.stamp;
      end
   end

endmodule

FILE: hw/rtl/per_flow_token_bucket_limiter.sv
// An item accepted in idle passes in order through the match, chain select, refill
// and final update states before its result is registered onto rsp; a stalled
// result holds the final step, and req_stall holds off new items until idle.
// Reset: synchronous, clears all entry valid bits and restores the registers
// to rate_shift 10, max_tokens 16 and tokens_per_packet 1.
// ----------------------------------------------------------------------------
// Per-flow token bucket limiter
// Classifies packet headers, keeps a token bucket per five-tuple flow in a
// chain of table cells and returns a verdict item for every header item.
// ----------------------------------------------------------------------------
`include "per_flow_token_bucket_limiter_assert.svh"

module per_flow_token_bucket_limiter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pftbl_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pftbl_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MATCH  = 3'd1;
   localparam logic [2:0] ST_SELECT = 3'd2;
   localparam logic [2:0] ST_GAIN   = 3'd3;
   localparam logic [2:0] ST_FINAL  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  shift_ff;
   logic [15:0] max_ff;
   logic [15:0] cost_ff;

   logic                        malformed_ff;
   logic                        fin_ff;
   logic [pftbl_pkg::KEY_W-1:0] key_ff;
   logic [63:0]                 now_ff;

   logic        hit_any_ff, free_any_ff;
   logic [15:0] tok_ff;
   logic [63:0] last_ff;
   logic        gain_big_ff;
   logic [15:0] gain_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   pftbl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   pftbl_pkg::cmd_type   cmd;
   pftbl_pkg::chain_type chain [pftbl_pkg::FLOW_ENTRIES+1];

   logic        accept;
   logic        fire;
   logic [63:0] shifted;
   logic [16:0] level;
   logic [15:0] remain;
   logic        short_tok;
   logic [15:0] init_tok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign fire      = (state_ff == ST_FINAL) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MATCH;
         ST_MATCH:  state_in = ST_SELECT;
         ST_SELECT: state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_FINAL;
         ST_FINAL:  if (fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= pftbl_pkg::RATE_SHIFT_RESET;
         max_ff       <= pftbl_pkg::MAX_TOKENS_RESET;
         cost_ff      <= pftbl_pkg::COST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pftbl_pkg::REG_RATE_SHIFT: shift_ff <= csr_wdata[5:0];
               pftbl_pkg::REG_MAX_TOKENS: max_ff   <= csr_wdata;
               pftbl_pkg::REG_COST:       cost_ff  <= csr_wdata;
               default:                   ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         malformed_ff <= !req_data.headers_complete
                      || (req_data.ether_type != pftbl_pkg::ETHERTYPE_IPV4)
                      || ((req_data.protocol != pftbl_pkg::PROTO_TCP)
                       && (req_data.protocol != pftbl_pkg::PROTO_UDP));
         fin_ff <= (req_data.protocol == pftbl_pkg::PROTO_TCP) && req_data.tcp_fin;
         key_ff <= {req_data.src_ip & pftbl_pkg::SRC_IP_MASK, req_data.dst_ip,
                    req_data.sport, req_data.dport, req_data.protocol};
         now_ff <= req_data.now_ns;
      end
      if (state_ff == ST_SELECT) begin
         hit_any_ff  <= chain[pftbl_pkg::FLOW_ENTRIES].hit_seen;
         free_any_ff <= chain[pftbl_pkg::FLOW_ENTRIES].free_seen;
         tok_ff      <= chain[pftbl_pkg::FLOW_ENTRIES].tokens;
         last_ff     <= chain[pftbl_pkg::FLOW_ENTRIES].stamp;
      end
      if (state_ff == ST_GAIN) begin
         gain_big_ff <= (shifted >= {48'd0, max_ff});
         gain_ff     <= shifted[15:0];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign shifted  = (now_ff - last_ff) >> shift_ff;
   assign init_tok = (max_ff >= cost_ff) ? (max_ff - cost_ff) : 16'd0;

   always_comb begin
      level = gain_big_ff ? {1'b0, max_ff} : ({1'b0, tok_ff} + {1'b0, gain_ff});
      if (level > {1'b0, max_ff}) begin
         level = {1'b0, max_ff};
      end
      short_tok = (level < {1'b0, cost_ff});
      remain    = short_tok ? level[15:0] : (level[15:0] - cost_ff);
   end

   always_comb begin
      rsp_data_in = '0;
      cmd         = '0;
      cmd.key     = key_ff;
      cmd.stamp   = now_ff;
      cmd.do_match  = (state_ff == ST_MATCH);
      cmd.do_select = (state_ff == ST_SELECT);
      if (malformed_ff) begin
         rsp_data_in.verdict = pftbl_pkg::VERDICT_MALFORMED;
      end else if (hit_any_ff) begin
         rsp_data_in.verdict      = short_tok ? pftbl_pkg::VERDICT_DROP_RATE
                                              : pftbl_pkg::VERDICT_PASS;
         rsp_data_in.flow_hit     = 1'b1;
         rsp_data_in.flow_removed = fin_ff;
         rsp_data_in.tokens_left  = fin_ff ? 16'd0 : remain;
         cmd.do_write_hit         = fire;
         cmd.wr_valid             = !fin_ff;
         cmd.tokens               = remain;
      end else if (!fin_ff) begin
         rsp_data_in.verdict = pftbl_pkg::VERDICT_PASS;
         if (free_any_ff) begin
            rsp_data_in.flow_inserted = 1'b1;
            rsp_data_in.tokens_left   = init_tok;
            cmd.do_write_ins          = fire;
            cmd.tokens                = init_tok;
         end else begin
            rsp_data_in.table_full = 1'b1;
         end
      end else begin
         rsp_data_in.verdict = pftbl_pkg::VERDICT_PASS;
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   assign chain[0] = '0;

   for (genvar i = 0; i < pftbl_pkg::FLOW_ENTRIES; i++) begin : g_cell
      pftbl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   `PFTBL_ASSERT_NEVER(a_no_bad_verdict, clock, reset,
      rsp_valid_ff && (rsp_data_ff.verdict == 2'd3), "verdict code out of range")
   `PFTBL_ASSERT_IMPLY(a_hit_no_insert, clock, reset, rsp_valid_ff && rsp_data_ff.flow_hit,
      !rsp_data_ff.flow_inserted && !rsp_data_ff.table_full, "hit item also inserted")
   `PFTBL_ASSERT_IMPLY(a_malformed_clean, clock, reset,
      rsp_valid_ff && (rsp_data_ff.verdict == pftbl_pkg::VERDICT_MALFORMED),
      (rsp_data_ff.tokens_left == 16'd0) && !rsp_data_ff.flow_hit,
      "malformed item carries flow data")
   `PFTBL_ASSERT_NEXT(a_fire_shows, clock, reset, fire,
      rsp_valid_ff && (state_ff == ST_IDLE), "finished item not presented")

endmodule
